>>> hdl/assert_macros.svh
// Assertion helpers for the RTL. Clock and reset names are fixed by the
// house style.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/opfr_pkg.sv
package opfr_pkg;

    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 64;
    localparam int CHUNK_BYTES_DEF  = 16;

    localparam int INIT_LEN = 26;
    localparam int POS_W    = 5;
    // Rows never exceed 63, so a row fits in six bits and a page in three.
    localparam int ROW_W    = 6;
    localparam int PAGE_W   = 3;

    typedef enum logic [2:0] {
        FUNC_PIXEL = 3'd0,
        FUNC_RECT  = 3'd1,
        FUNC_INIT  = 3'd2,
        FUNC_FLUSH = 3'd3,
        FUNC_PULL  = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        CFG_COLUMN_OFFSET  = 2'd0,
        CFG_PAGE_OFFSET    = 2'd1,
        CFG_CONTRAST_LEVEL = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_INIT  = 2'd1,
        MODE_FLUSH = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_PAGECMD  = 2'd1,
        PH_DATAMODE = 2'd2,
        PH_DATA     = 2'd3
    } t_phase;

    localparam logic [7:0] BYTE_CMD_MODE  = 8'h00;
    localparam logic [7:0] BYTE_DATA_MODE = 8'h40;
    localparam logic [7:0] BYTE_PAGE_BASE = 8'hB0;
    localparam logic [7:0] BYTE_COL_HIGH  = 8'h10;

    // Controller init command stream; the multiplex ratio and contrast bytes
    // come from the panel height and the contrast register.
    function automatic logic [7:0] init_byte(input logic [POS_W-1:0] k,
                                             input logic [7:0] mux_ratio,
                                             input logic [7:0] contrast);
        logic [7:0] b;
        case (k)
            5'd0:  b = 8'h00;
            5'd1:  b = 8'hAE;
            5'd2:  b = 8'hD5;
            5'd3:  b = 8'h80;
            5'd4:  b = 8'hA8;
            5'd5:  b = mux_ratio;
            5'd6:  b = 8'hD3;
            5'd7:  b = 8'h00;
            5'd8:  b = 8'h40;
            5'd9:  b = 8'h8D;
            5'd10: b = 8'h14;
            5'd11: b = 8'h20;
            5'd12: b = 8'h00;
            5'd13: b = 8'hA1;
            5'd14: b = 8'hC8;
            5'd15: b = 8'hDA;
            5'd16: b = 8'h12;
            5'd17: b = 8'h81;
            5'd18: b = contrast;
            5'd19: b = 8'hD9;
            5'd20: b = 8'hF1;
            5'd21: b = 8'hDB;
            5'd22: b = 8'h40;
            5'd23: b = 8'hA4;
            5'd24: b = 8'hA6;
            5'd25: b = 8'hAF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/oled_page_framebuffer_refresh_unit.sv
// Channel  | Handshake          | Beat contents
// ---------+--------------------+----------------------------------------------
// input    | i_valid / o_ready  | i_func, i_pos_x, i_pos_y, i_rect_width,
//          |                    | i_rect_height, i_ink
// output   | o_valid / i_ready  | o_out_byte, o_txn_first, o_txn_last, o_seq_last
// config   | i_cfg_valid /      | i_cfg_index, i_cfg_data
//          | o_cfg_ready        |
//
// A pull of a command or mode byte is answered from the idle state. A pull of a
// frame data byte first reads the framebuffer memory, then sends the byte and
// writes it back as zero. A pixel or a rectangle is taken in the idle state, then
// each touched framebuffer byte is a read then a write on the single memory.
// After reset a clearing pass writes zero to every framebuffer byte, one per
// cycle, before the first input beat is taken.
// A result beat waiting on the output holds o_ready low for every kind of input
// beat until the waiting beat leaves.
module oled_page_framebuffer_refresh_unit #(
    parameter int PANEL_WIDTH  = opfr_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = opfr_pkg::PANEL_HEIGHT_DEF,
    parameter int CHUNK_BYTES  = opfr_pkg::CHUNK_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_func,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic [7:0] i_rect_width,
    input  logic [7:0] i_rect_height,
    input  logic       i_ink,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_txn_first,
    output logic       o_txn_last,
    output logic       o_seq_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    `include "assert_macros.svh"

    localparam int PAGES   = (PANEL_HEIGHT + 7) / 8;
    localparam int DEPTH   = PANEL_WIDTH * PAGES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COL_W   = $clog2(PANEL_WIDTH);
    localparam int CHUNK_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(PANEL_WIDTH - 1);
    localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNK_BYTES - 1);
    localparam logic [opfr_pkg::PAGE_W-1:0] PAGE_LAST = opfr_pkg::PAGE_W'(PAGES - 1);
    localparam logic [ADDR_W-1:0]  ADDR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [8:0]         W9         = 9'(PANEL_WIDTH);
    localparam logic [8:0]         H9         = 9'(PANEL_HEIGHT);
    localparam logic [7:0]         MUX_RATIO  = 8'(PANEL_HEIGHT - 1);

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD   = 5'b00100,
        S_WR   = 5'b01000,
        S_PULL = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers; the port never stalls.
    logic [6:0] r_col_off;
    logic [2:0] r_page_off;
    logic [7:0] r_contrast;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_off  <= 7'd2;
            r_page_off <= 3'd0;
            r_contrast <= 8'd207;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                opfr_pkg::CFG_COLUMN_OFFSET:  r_col_off  <= i_cfg_data[6:0];
                opfr_pkg::CFG_PAGE_OFFSET:    r_page_off <= i_cfg_data[2:0];
                opfr_pkg::CFG_CONTRAST_LEVEL: r_contrast <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stream state.
    opfr_pkg::t_mode  r_mode, n_mode;
    opfr_pkg::t_phase r_phase, n_phase;
    logic [opfr_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [opfr_pkg::PAGE_W-1:0] r_fpage, n_fpage;
    logic [COL_W-1:0]            r_fcol, n_fcol;
    logic [CHUNK_W-1:0]          r_chunk, n_chunk;

    // Rectangle walk state.
    logic [COL_W-1:0]            r_rx0, r_rx, r_rxl, n_rx0, n_rx, n_rxl;
    logic [opfr_pkg::PAGE_W-1:0] r_rp, n_rp;
    logic [opfr_pkg::ROW_W-1:0]  r_ys, r_yl, n_ys, n_yl;
    logic                        r_ink, n_ink;
    logic [ADDR_W-1:0]           r_clr, n_clr;

    // Output register.
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_first, r_last, r_seq, n_first, n_last, n_seq;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr, rect_addr, flush_addr;
    logic [7:0]        mem_wdata, mem_rdata;

    opfr_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign rect_addr  = ADDR_W'(r_rp * PANEL_WIDTH) + ADDR_W'(r_rx);
    assign flush_addr = ADDR_W'(r_fpage * PANEL_WIDTH) + ADDR_W'(r_fcol);

    // A pull needs the output register free by the accepting edge.
    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);

    logic       accept;
    logic [8:0] xe, ye, x9, y9;
    logic       is_pixel;
    logic [2:0] m_lo, m_hi;
    logic [7:0] mask;
    logic       col_end, chunk_end;

    assign accept   = i_valid && o_ready;
    assign is_pixel = (i_func == opfr_pkg::FUNC_PIXEL);

    always_comb begin
        x9 = {1'b0, i_pos_x};
        y9 = {1'b0, i_pos_y};
        // A pixel is handled as a one by one rectangle.
        xe = is_pixel ? x9 + 9'd1 : x9 + {1'b0, i_rect_width};
        ye = is_pixel ? y9 + 9'd1 : y9 + {1'b0, i_rect_height};
        if (xe > W9) begin
            xe = W9;
        end
        if (ye > H9) begin
            ye = H9;
        end
        m_lo = (r_rp == r_ys[5:3]) ? r_ys[2:0] : 3'd0;
        m_hi = (r_rp == r_yl[5:3]) ? r_yl[2:0] : 3'd7;
        mask = (8'hFF << m_lo) & (8'hFF >> (3'd7 - m_hi));
        col_end   = (r_fcol == COL_LAST);
        chunk_end = col_end || (r_chunk == CHUNK_LAST);
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_fpage     = r_fpage;
        n_fcol      = r_fcol;
        n_chunk     = r_chunk;
        n_rx0       = r_rx0;
        n_rx        = r_rx;
        n_rxl       = r_rxl;
        n_rp        = r_rp;
        n_ys        = r_ys;
        n_yl        = r_yl;
        n_ink       = r_ink;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_first     = r_first;
        n_last      = r_last;
        n_seq       = r_seq;
        mem_we      = 1'b0;
        mem_waddr   = rect_addr;
        mem_wdata   = 8'h00;
        mem_re      = 1'b0;
        mem_raddr   = rect_addr;

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == ADDR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_func == opfr_pkg::FUNC_PULL) begin
                        if (r_mode == opfr_pkg::MODE_INIT) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = opfr_pkg::init_byte(r_pos, MUX_RATIO, r_contrast);
                            n_first     = (r_pos == '0);
                            n_last      = (r_pos == opfr_pkg::POS_W'(opfr_pkg::INIT_LEN - 1));
                            n_seq       = n_last;
                            n_pos       = n_last ? '0 : r_pos + 1'b1;
                            if (n_last) begin
                                n_mode = opfr_pkg::MODE_IDLE;
                            end
                        end else if (r_mode == opfr_pkg::MODE_FLUSH) begin
                            n_seq = 1'b0;
                            unique case (r_phase) inside
                                opfr_pkg::PH_HEADER, opfr_pkg::PH_PAGECMD: begin
                                    n_out_valid = 1'b1;
                                    n_first     = (r_pos == '0);
                                    n_last      = (r_pos[1:0] == 2'd3);
                                    case (r_pos[1:0])
                                        2'd0: n_out_byte = opfr_pkg::BYTE_CMD_MODE;
                                        2'd1: n_out_byte = (r_phase == opfr_pkg::PH_HEADER)
                                            ? opfr_pkg::BYTE_CMD_MODE
                                            : opfr_pkg::BYTE_PAGE_BASE + 8'(r_fpage)
                                              + 8'(r_page_off);
                                        2'd2: n_out_byte = (r_phase == opfr_pkg::PH_HEADER)
                                            ? opfr_pkg::BYTE_COL_HIGH
                                            : opfr_pkg::BYTE_COL_HIGH | 8'(r_col_off[6:4]);
                                        default: n_out_byte = (r_phase == opfr_pkg::PH_HEADER)
                                            ? opfr_pkg::BYTE_DATA_MODE
                                            : 8'(r_col_off[3:0]);
                                    endcase
                                    n_pos = r_pos + 1'b1;
                                    if (n_last) begin
                                        n_pos = '0;
                                        if (r_phase == opfr_pkg::PH_HEADER) begin
                                            n_phase = opfr_pkg::PH_PAGECMD;
                                            n_fpage = '0;
                                        end else begin
                                            n_phase = opfr_pkg::PH_DATAMODE;
                                            n_fcol  = '0;
                                        end
                                    end
                                end
                                opfr_pkg::PH_DATAMODE: begin
                                    n_out_valid = 1'b1;
                                    n_out_byte  = opfr_pkg::BYTE_DATA_MODE;
                                    n_first     = 1'b1;
                                    n_last      = 1'b0;
                                    n_phase     = opfr_pkg::PH_DATA;
                                    n_chunk     = '0;
                                end
                                opfr_pkg::PH_DATA: begin
                                    mem_re    = 1'b1;
                                    mem_raddr = flush_addr;
                                    n_state   = S_PULL;
                                end
                            endcase
                        end
                    end else if (r_mode == opfr_pkg::MODE_IDLE) begin
                        case (i_func) inside
                            opfr_pkg::FUNC_PIXEL, opfr_pkg::FUNC_RECT: begin
                                if (x9 < xe && y9 < ye) begin
                                    n_rx0   = COL_W'(i_pos_x);
                                    n_rx    = COL_W'(i_pos_x);
                                    n_rxl   = COL_W'(xe - 9'd1);
                                    n_ys    = i_pos_y[opfr_pkg::ROW_W-1:0];
                                    n_yl    = opfr_pkg::ROW_W'(ye - 9'd1);
                                    n_rp    = i_pos_y[5:3];
                                    n_ink   = i_ink;
                                    n_state = S_RD;
                                end
                            end
                            opfr_pkg::FUNC_INIT: begin
                                n_mode = opfr_pkg::MODE_INIT;
                                n_pos  = '0;
                            end
                            opfr_pkg::FUNC_FLUSH: begin
                                n_mode  = opfr_pkg::MODE_FLUSH;
                                n_pos   = '0;
                                n_phase = opfr_pkg::PH_HEADER;
                                n_fpage = '0;
                                n_fcol  = '0;
                                n_chunk = '0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_ink ? (mem_rdata | mask) : (mem_rdata & ~mask);
                n_state   = S_RD;
                if (r_rx == r_rxl) begin
                    n_rx = r_rx0;
                    n_rp = r_rp + 1'b1;
                    if (r_rp == r_yl[5:3]) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_rx = r_rx + 1'b1;
                end
            end
            S_PULL: begin
                // Send the byte and clear it behind the stream.
                mem_we      = 1'b1;
                mem_waddr   = flush_addr;
                n_out_valid = 1'b1;
                n_out_byte  = mem_rdata;
                n_first     = 1'b0;
                n_last      = chunk_end;
                n_seq       = col_end && (r_fpage == PAGE_LAST);
                n_fcol      = r_fcol + 1'b1;
                n_chunk     = r_chunk + 1'b1;
                n_state     = S_IDLE;
                if (col_end) begin
                    n_pos = '0;
                    if (r_fpage == PAGE_LAST) begin
                        n_mode  = opfr_pkg::MODE_IDLE;
                        n_phase = opfr_pkg::PH_HEADER;
                        n_fpage = '0;
                        n_fcol  = '0;
                        n_chunk = '0;
                    end else begin
                        n_fpage = r_fpage + 1'b1;
                        n_phase = opfr_pkg::PH_PAGECMD;
                    end
                end else if (chunk_end) begin
                    n_phase = opfr_pkg::PH_DATAMODE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_mode      <= opfr_pkg::MODE_IDLE;
            r_phase     <= opfr_pkg::PH_HEADER;
            r_pos       <= '0;
            r_fpage     <= '0;
            r_fcol      <= '0;
            r_chunk     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_fpage     <= n_fpage;
            r_fcol      <= n_fcol;
            r_chunk     <= n_chunk;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx0      <= n_rx0;
        r_rx       <= n_rx;
        r_rxl      <= n_rxl;
        r_rp       <= n_rp;
        r_ys       <= n_ys;
        r_yl       <= n_yl;
        r_ink      <= n_ink;
        r_out_byte <= n_out_byte;
        r_first    <= n_first;
        r_last     <= n_last;
        r_seq      <= n_seq;
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_txn_first = r_first;
    assign o_txn_last  = r_last;
    assign o_seq_last  = r_seq;

    // A data pull always finds the output register empty.
    `ASSERT_IMPLIES(a_pull_out_free, r_state == S_PULL, !r_out_valid)
    // The memory is written only by the clearing pass, a draw or a data pull.
    `ASSERT_IMPLIES(a_mem_we_state, mem_we,
        r_state == S_CLR || r_state == S_WR || r_state == S_PULL)
    // An idle stream always restarts from the flush header.
    `ASSERT_IMPLIES(a_idle_phase, r_mode == opfr_pkg::MODE_IDLE,
        r_phase == opfr_pkg::PH_HEADER)
    // The end of a sequence also ends its transaction.
    `ASSERT_ALWAYS(a_seq_ends_txn, !(r_out_valid && r_seq && !r_last))

endmodule

>>> hdl/opfr_mem.sv
module opfr_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
